// ----- sv/afc_pkg.sv -----
package afc_pkg;

    localparam int MAX_EDGE_DEF        = 256;
    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam logic [8:0] NO_TRANSPARENT = 9'd256;
    localparam logic [7:0] ALPHA_FULL     = 8'd255;

    localparam logic [1:0] DISP_BACKGROUND = 2'd2;
    localparam logic [1:0] DISP_PREVIOUS   = 2'd3;

    localparam logic [1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PALETTE_COUNT = 2'd2;

    localparam logic [8:0] CFG_WIDTH_RESET   = 9'd256;
    localparam logic [8:0] CFG_HEIGHT_RESET  = 9'd256;
    localparam logic [8:0] CFG_PALETTE_RESET = 9'd256;

    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_BEGIN = 3'd1,
        CMD_PIXEL = 3'd2,
        CMD_END   = 3'd3,
        CMD_READ  = 3'd4,
        CMD_CLEAR = 3'd5
    } cmd_e;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PIX,
        ST_READ,
        ST_CLEAR,
        ST_SAVE,
        ST_RESTORE,
        ST_TAIL,
        ST_WALK
    } state_e;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  color_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [8:0]  transparent_index;
        logic [1:0]  disposal;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } out_item_t;

    typedef struct packed {
        logic take;
        logic pix_wr;
        logic rd_done;
        logic clr_step;
        logic copy_step;
        logic copy_restore;
        logic walk_step;
    } ctl_cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic [1:0] disp_in;
        logic [1:0] disp_frame;
        logic       walk_empty;
        logic       walk_last;
        logic       cnt_last;
        logic       out_free;
    } dp_sts_t;

endpackage

// ----- sv/afc_ram.sv -----
module afc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/afc_ctrl.sv -----
module afc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  afc_pkg::dp_sts_t   sts,
    output afc_pkg::ctl_cmd_t  cmd
);
    import afc_pkg::*;

    state_e state_reg;
    state_e state_next;
    logic   take;

    assign take = (state_reg == ST_IDLE) && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                if (sts.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    case (sts.command)
                        CMD_BEGIN:
                        begin
                            if (sts.disp_in == DISP_PREVIOUS)
                            begin
                                state_next = ST_SAVE;
                            end
                        end
                        CMD_PIXEL: state_next = ST_PIX;
                        CMD_END:
                        begin
                            if (sts.disp_frame == DISP_PREVIOUS)
                            begin
                                state_next = ST_RESTORE;
                            end
                            else if (sts.disp_frame == DISP_BACKGROUND && !sts.walk_empty)
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        CMD_READ:  state_next = ST_READ;
                        CMD_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX: state_next = ST_IDLE;
            ST_READ:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SAVE, ST_RESTORE:
            begin
                if (sts.cnt_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: state_next = ST_IDLE;
            ST_WALK:
            begin
                if (sts.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready         = (state_reg == ST_IDLE);
        cmd              = '0;
        cmd.take         = take;
        cmd.pix_wr       = (state_reg == ST_PIX);
        cmd.rd_done      = (state_reg == ST_READ) && sts.out_free;
        cmd.clr_step     = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
        cmd.copy_step    = (state_reg == ST_SAVE) || (state_reg == ST_RESTORE);
        cmd.copy_restore = (state_reg == ST_RESTORE);
        cmd.walk_step    = (state_reg == ST_WALK);
    end

endmodule

// ----- sv/afc_dp.sv -----
module afc_dp #(
    parameter int MAX_EDGE        = afc_pkg::MAX_EDGE_DEF,
    parameter int PALETTE_ENTRIES = afc_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  afc_pkg::in_item_t  in_data,
    output afc_pkg::out_item_t out_data,
    output logic               out_valid,
    input  logic               out_ready,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    input  afc_pkg::ctl_cmd_t  cmd,
    output afc_pkg::dp_sts_t   sts
);
    import afc_pkg::*;

    localparam int DEPTH = MAX_EDGE * MAX_EDGE;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_EDGE);
    localparam int CW    = $clog2(MAX_EDGE + 1);
    localparam int PW    = $clog2(PALETTE_ENTRIES);

    logic [8:0]  cw_reg, ch_reg, pc_reg;
    logic [15:0] left_reg, top_reg, w_reg, h_reg, col_reg, row_reg;
    logic [8:0]  trans_reg;
    logic [1:0]  disp_reg;

    logic          pix_we_reg;
    logic [AW-1:0] pix_addr_reg;
    logic          rd_in_reg;

    logic [AW-1:0] cnt_reg;
    logic          pend_reg, pend_restore_reg;
    logic [AW-1:0] pend_addr_reg;

    logic [XW-1:0] wx_reg, wy_reg, wl_reg;
    logic [CW-1:0] xe_reg, ye_reg;

    out_item_t out_reg;
    logic      out_valid_reg;

    logic [16:0] effw, effh, lim, x_sum, y_sum, xe_sum, ye_sum;
    logic [8:0]  idx9;
    logic        active, pix_ok, rd_inside, walk_empty, walk_row_end;
    logic [AW-1:0] pix_addr, rd_addr, walk_addr;

    logic          cv_we, cv_re, bk_we, bk_re, pal_we, pal_re;
    logic [AW-1:0] cv_waddr, cv_raddr;
    logic [24:0]   cv_wdata, cv_rdata, bk_rdata;
    logic [23:0]   pal_rdata;

    // Canvas and palette limits clipped to the store sizes.
    always_comb
    begin
        effw = (17'(cw_reg) > 17'(MAX_EDGE)) ? 17'(MAX_EDGE) : 17'(cw_reg);
        effh = (17'(ch_reg) > 17'(MAX_EDGE)) ? 17'(MAX_EDGE) : 17'(ch_reg);
        lim  = (17'(pc_reg) > 17'(PALETTE_ENTRIES)) ? 17'(PALETTE_ENTRIES)
                                                   : 17'(pc_reg);
    end

    always_comb
    begin
        idx9   = {1'b0, in_data.color_index};
        active = (w_reg != 16'd0) && (row_reg < h_reg);
        x_sum  = 17'(left_reg) + 17'(col_reg);
        y_sum  = 17'(top_reg) + 17'(row_reg);
        pix_ok = active && (idx9 != trans_reg) && (17'(idx9) < lim)
                 && (x_sum < effw) && (y_sum < effh);
        pix_addr = AW'(y_sum[XW-1:0]) * AW'(MAX_EDGE) + AW'(x_sum[XW-1:0]);

        rd_inside = (17'(in_data.x_pos) < effw) && (17'(in_data.y_pos) < effh);
        rd_addr   = AW'(in_data.y_pos[XW-1:0]) * AW'(MAX_EDGE)
                    + AW'(in_data.x_pos[XW-1:0]);

        xe_sum = 17'(left_reg) + 17'(w_reg);
        ye_sum = 17'(top_reg) + 17'(h_reg);
        walk_empty = (w_reg == 16'd0) || (h_reg == 16'd0)
                     || (17'(left_reg) >= effw) || (17'(top_reg) >= effh);
        walk_row_end = (CW'(wx_reg) + CW'(1)) == xe_reg;
        walk_addr = AW'(wy_reg) * AW'(MAX_EDGE) + AW'(wx_reg);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= CFG_WIDTH_RESET;
            ch_reg <= CFG_HEIGHT_RESET;
            pc_reg <= CFG_PALETTE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CANVAS_WIDTH:  cw_reg <= cfg_data;
                CFG_CANVAS_HEIGHT: ch_reg <= cfg_data;
                CFG_PALETTE_COUNT: pc_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            top_reg   <= '0;
            w_reg     <= '0;
            h_reg     <= '0;
            trans_reg <= NO_TRANSPARENT;
            disp_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else if (cmd.take)
        begin
            case (in_data.command)
                CMD_BEGIN:
                begin
                    left_reg  <= in_data.x_pos;
                    top_reg   <= in_data.y_pos;
                    w_reg     <= in_data.frame_width;
                    h_reg     <= in_data.frame_height;
                    trans_reg <= in_data.transparent_index;
                    disp_reg  <= in_data.disposal;
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                CMD_PIXEL:
                begin
                    if (active)
                    begin
                        if (col_reg + 16'd1 >= w_reg)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 16'd1;
                        end
                        else
                        begin
                            col_reg <= col_reg + 16'd1;
                        end
                    end
                end
                CMD_END:
                begin
                    left_reg  <= '0;
                    top_reg   <= '0;
                    w_reg     <= '0;
                    h_reg     <= '0;
                    trans_reg <= NO_TRANSPARENT;
                    disp_reg  <= '0;
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                default: ;
            endcase
        end
    end

    // Sweep counter, copy pipeline and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            pend_restore_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.clr_step || cmd.copy_step)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end
            pend_reg         <= cmd.copy_step;
            pend_restore_reg <= cmd.copy_restore;
            if (cmd.rd_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= cnt_reg;
        if (cmd.take)
        begin
            pix_we_reg   <= pix_ok && (in_data.command == CMD_PIXEL);
            pix_addr_reg <= pix_addr;
            rd_in_reg    <= rd_inside;
            if (in_data.command == CMD_END)
            begin
                wx_reg <= left_reg[XW-1:0];
                wl_reg <= left_reg[XW-1:0];
                wy_reg <= top_reg[XW-1:0];
                xe_reg <= (xe_sum < effw) ? xe_sum[CW-1:0] : effw[CW-1:0];
                ye_reg <= (ye_sum < effh) ? ye_sum[CW-1:0] : effh[CW-1:0];
            end
        end
        else if (cmd.walk_step)
        begin
            if (walk_row_end)
            begin
                wx_reg <= wl_reg;
                wy_reg <= wy_reg + XW'(1);
            end
            else
            begin
                wx_reg <= wx_reg + XW'(1);
            end
        end
        if (cmd.rd_done)
        begin
            if (rd_in_reg)
            begin
                out_reg.out_red   <= cv_rdata[23:16];
                out_reg.out_green <= cv_rdata[15:8];
                out_reg.out_blue  <= cv_rdata[7:0];
                out_reg.out_alpha <= cv_rdata[24] ? ALPHA_FULL : 8'd0;
            end
            else
            begin
                out_reg <= '0;
            end
        end
    end

    // Memory port selection.
    always_comb
    begin
        cv_we    = 1'b0;
        cv_waddr = cnt_reg;
        cv_wdata = '0;
        if (cmd.clr_step)
        begin
            cv_we = 1'b1;
        end
        else if (pend_reg && pend_restore_reg)
        begin
            cv_we    = 1'b1;
            cv_waddr = pend_addr_reg;
            cv_wdata = bk_rdata;
        end
        else if (cmd.pix_wr && pix_we_reg)
        begin
            cv_we    = 1'b1;
            cv_waddr = pix_addr_reg;
            cv_wdata = {1'b1, pal_rdata};
        end
        else if (cmd.walk_step)
        begin
            cv_we    = 1'b1;
            cv_waddr = walk_addr;
        end
        cv_re    = (cmd.copy_step && !cmd.copy_restore)
                   || (cmd.take && in_data.command == CMD_READ);
        cv_raddr = cmd.copy_step ? cnt_reg : rd_addr;
        bk_we    = pend_reg && !pend_restore_reg;
        bk_re    = cmd.copy_step && cmd.copy_restore;
        pal_we   = cmd.take && (in_data.command == CMD_LOAD)
                   && (idx9 < 9'(PALETTE_ENTRIES));
        pal_re   = cmd.take && (in_data.command == CMD_PIXEL);
    end

    afc_ram #(.WIDTH(25), .DEPTH(DEPTH)) u_canvas (
        .clk   (clk),
        .we    (cv_we),
        .waddr (cv_waddr),
        .wdata (cv_wdata),
        .re    (cv_re),
        .raddr (cv_raddr),
        .rdata (cv_rdata)
    );

    afc_ram #(.WIDTH(25), .DEPTH(DEPTH)) u_backup (
        .clk   (clk),
        .we    (bk_we),
        .waddr (pend_addr_reg),
        .wdata (cv_rdata),
        .re    (bk_re),
        .raddr (cnt_reg),
        .rdata (bk_rdata)
    );

    afc_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (in_data.color_index[PW-1:0]),
        .wdata ({in_data.red, in_data.green, in_data.blue}),
        .re    (pal_re),
        .raddr (in_data.color_index[PW-1:0]),
        .rdata (pal_rdata)
    );

    always_comb
    begin
        sts            = '0;
        sts.command    = in_data.command;
        sts.disp_in    = in_data.disposal;
        sts.disp_frame = disp_reg;
        sts.walk_empty = walk_empty;
        sts.walk_last  = walk_row_end && ((CW'(wy_reg) + CW'(1)) == ye_reg);
        sts.cnt_last   = (cnt_reg == AW'(DEPTH - 1));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

// ----- sv/animated_frame_compositor.sv -----
// Channel    | Handshake              | Payload
// -----------+------------------------+--------------------------------------
// input      | in_valid / in_ready    | in_data  (afc_pkg::in_item_t)
// output     | out_valid / out_ready  | out_data (afc_pkg::out_item_t)
// config     | cfg_valid / cfg_ready  | cfg_index, cfg_data (9 bits)
//
// Palette loads and ignored commands finish in the idle state where they are
// taken; a pixel is taken in the idle state and written in the pixel state,
// and a read waits in the read state until the output register is free.
// A clear sweeps the canvas store at one entry a cycle, and a begin or end
// with restore-previous disposal copies the whole canvas through one memory
// port pair. Background disposal walks the clipped frame rectangle, one pixel
// a cycle. After reset the canvas is cleared before the first input
// transaction is taken; config writes are taken at any time.
module animated_frame_compositor #(
    parameter int MAX_EDGE        = afc_pkg::MAX_EDGE_DEF,
    parameter int PALETTE_ENTRIES = afc_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  afc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output afc_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data
);
    import afc_pkg::*;

    ctl_cmd_t ctl_cmd;
    dp_sts_t  dp_sts;

    // Configuration registers live in flops and can always take a transaction.
    assign cfg_ready = 1'b1;

    // The controller sequences sweeps, walks and per-transaction steps.
    afc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (dp_sts),
        .cmd      (ctl_cmd)
    );

    // The datapath holds frame state, the three stores and the output register.
    afc_dp #(
        .MAX_EDGE        (MAX_EDGE),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (ctl_cmd),
        .sts       (dp_sts)
    );

endmodule
